// ===== rtl/core/psr_pkg.sv =====
// psr_pkg: shared constants, types and arithmetic helpers of the pixelwise stack reducer
// no dependencies; imported by every other file of the block
package psr_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int PIX_W      = $clog2(MAX_PIXELS);
   localparam int LANES      = 4;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ACC_W      = 48;
   localparam int SMP_W      = 32;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);

   // csr register indexes
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_CHANNELS = 2'd1;
   localparam logic [1:0] CSR_IMAGES   = 2'd2;

   typedef enum logic [2:0] {
      MODE_SUM, MODE_AVG, MODE_HYPOT, MODE_PROD,
      MODE_MIN, MODE_MAX, MODE_NMIN, MODE_NMAX
   } mode_type;

   typedef enum logic [2:0] {
      OP_STORE, OP_ADD, OP_HYPOT, OP_MUL, OP_MIN, OP_MAX, OP_NMIN, OP_NMAX
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_MUL_LO, ST_MUL_HI, ST_MUL_FIN, ST_SQ_A, ST_SQ_X,
      ST_SQRT, ST_HYP_FIN, ST_NSQ, ST_NCMP, ST_DIV_LOAD, ST_DIV, ST_DONE
   } st_type;

   typedef logic [LANES-1:0][ACC_W-1:0] row_type;
   typedef logic [LANES-1:0][SMP_W-1:0] smp_row_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic              last;
      op_type            op;
      logic              dvd;
      logic [LANE_W-1:0] lanes_m1;
      smp_row_type       x;
   } entry_type;

   localparam logic signed [ACC_W-1:0] POS48 = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] NEG48 = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic logic [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
      logic [ACC_W-1:0] r;
      if (v > $signed({1'b0, POS48}))      r = POS48;
      else if (v < $signed({1'b1, NEG48})) r = NEG48;
      else                                 r = v[ACC_W-1:0];
      return r;
   endfunction

   function automatic logic [SMP_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
      logic [SMP_W-1:0] r;
      if (v > 48'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -48'sd2147483648) r = 32'h8000_0000;
      else                           r = v[SMP_W-1:0];
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? (~v + 48'd1) : v;
   endfunction

   // magnitude limited to 2^31
   function automatic logic [31:0] mag31(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] m;
      m = mag48(v);
      return (m > 48'h8000_0000) ? 32'h8000_0000 : m[31:0];
   endfunction

endpackage

// ===== rtl/core/psr_ifs.sv =====
// psr_req_if / psr_rsp_if: valid-ready channels of the stack reducer
// depends on psr_pkg
interface psr_req_if import psr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [15:0]             pixel_index;
   logic                    first_image;
   logic                    last_image;
   logic signed [SMP_W-1:0] lane0;
   logic signed [SMP_W-1:0] lane1;
   logic signed [SMP_W-1:0] lane2;
   logic signed [SMP_W-1:0] lane3;
   modport source (output valid, pixel_index, first_image, last_image,
                   lane0, lane1, lane2, lane3, input ready);
   modport sink   (input valid, pixel_index, first_image, last_image,
                   lane0, lane1, lane2, lane3, output ready);
endinterface

interface psr_rsp_if import psr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [15:0]             out_pixel;
   logic signed [SMP_W-1:0] out_lane0;
   logic signed [SMP_W-1:0] out_lane1;
   logic signed [SMP_W-1:0] out_lane2;
   logic signed [SMP_W-1:0] out_lane3;
   modport source (output valid, out_pixel, out_lane0, out_lane1, out_lane2,
                   out_lane3, input ready);
   modport sink   (input valid, out_pixel, out_lane0, out_lane1, out_lane2,
                   out_lane3, output ready);
endinterface

// ===== rtl/core/pixelwise_stack_reducer.sv =====
// pixelwise_stack_reducer: top level, front classifier, request queue and back sequencer
// depends on psr_pkg, psr_ifs, psr_front, psr_queue, psr_back
//
//  channel  | direction | handshake        | payload
//  req_ch   | in        | valid/ready      | pixel_index, first/last_image, lane0..3
//  rsp_ch   | out       | valid/ready      | out_pixel, out_lane0..3
//  csr      | in        | csr_wr_en        | csr_index, csr_wr_data
//
// store, sum, min and max requests retire one per cycle through the back sequencer, unless
// a last image waits for a busy result register. per lane, product multiplies low and high
// halves, hypot takes one sqrt digit a cycle, norm modes square then compare, and average
// on the last image divides. reset is synchronous; the accumulator memory is not cleared.
// a 4-entry queue lets requests be taken while the back works or a result waits.
module pixelwise_stack_reducer import psr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   psr_req_if.sink      req_ch,
   psr_rsp_if.source    rsp_ch,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wr_data
);

   logic        q_push, q_ready, q_pop, head_valid;
   entry_type   q_entry, head;
   logic [15:0] cdiv;

   psr_front u_front (
      .clock, .reset, .req_ch, .csr_wr_en, .csr_index, .csr_wr_data,
      .q_ready, .q_push, .q_entry, .cdiv
   );

   psr_queue u_queue (
      .clock, .reset, .push(q_push), .push_entry(q_entry), .ready(q_ready),
      .pop(q_pop), .head_valid, .head
   );

   psr_back u_back (
      .clock, .reset, .head_valid, .head, .pop(q_pop), .cdiv, .rsp_ch
   );

endmodule

// ===== rtl/core/psr_front.sv =====
// psr_front: csr registers, request acceptance and classification into queue entries
// depends on psr_pkg and psr_req_if
module psr_front import psr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   psr_req_if.sink      req_ch,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wr_data,
   input  logic         q_ready,
   output logic         q_push,
   output entry_type    q_entry,
   output logic [15:0]  cdiv
);

   mode_type    mode_ff;
   logic [2:0]  chan_ff;
   logic [15:0] imgs_ff;
   logic [2:0]  n_eff;
   logic        in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUM;
         chan_ff <= 3'd1;
         imgs_ff <= 16'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff <= mode_type'(csr_wr_data[2:0]);
            CSR_CHANNELS: chan_ff <= csr_wr_data[2:0];
            CSR_IMAGES:   imgs_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (chan_ff == 3'd0)                    n_eff = 3'd1;
      else if ({1'b0, chan_ff} > 4'(LANES))   n_eff = 3'(LANES);
      else                                    n_eff = chan_ff;
   end

   assign in_range = (32'(req_ch.pixel_index) < 32'(MAX_PIXELS));
   assign req_ch.ready = q_ready;
   assign q_push = req_ch.valid && q_ready && in_range;
   assign cdiv = (imgs_ff == 16'd0) ? 16'd1 : imgs_ff;

   always_comb begin
      q_entry.pixel    = req_ch.pixel_index[PIX_W-1:0];
      q_entry.last     = req_ch.last_image;
      q_entry.dvd      = (mode_ff == MODE_AVG) && req_ch.last_image;
      q_entry.lanes_m1 = LANE_W'(n_eff - 3'd1);
      q_entry.x        = {req_ch.lane3, req_ch.lane2, req_ch.lane1, req_ch.lane0};
      if (req_ch.first_image) begin
         q_entry.op = OP_STORE;
      end else begin
         unique case (mode_ff)
            MODE_SUM, MODE_AVG: q_entry.op = OP_ADD;
            MODE_HYPOT:         q_entry.op = OP_HYPOT;
            MODE_PROD:          q_entry.op = OP_MUL;
            MODE_MIN:           q_entry.op = OP_MIN;
            MODE_MAX:           q_entry.op = OP_MAX;
            MODE_NMIN:          q_entry.op = OP_NMIN;
            default:            q_entry.op = OP_NMAX;
         endcase
      end
   end

endmodule

// ===== rtl/core/psr_queue.sv =====
// psr_queue: short fifo of classified requests between front and back
// depends on psr_pkg
module psr_queue import psr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      ready,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   entry_type          q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push, do_pop;

   assign ready      = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign do_push    = push && ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== rtl/core/psr_back.sv =====
// psr_back: accumulator memory, combine sequencer, divider/sqrt units and result register
// depends on psr_pkg and psr_rsp_if
module psr_back import psr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head,
   output logic        pop,
   input  logic [15:0] cdiv,
   psr_rsp_if.source   rsp_ch
);

   row_type            mem [MAX_PIXELS];
   st_type             st_ff, st_in;
   entry_type          ex_ff;
   row_type            mem_rd_ff, fwd_row_ff, new_ff, dq_ff;
   logic               fwd_ff;
   logic [LANE_W-1:0]  lane_ff;
   logic [5:0]         k_ff;
   logic [63:0]        prod_ff;
   logic [47:0]        prodh_ff;
   logic [63:0]        sq_n_ff, sq_r_ff;
   logic [64:0]        nacc_a_ff, nacc_x_ff;
   logic               nsel_ff;
   logic [47:0]        div_num_ff;
   logic [15:0]        div_rem_ff;
   logic               out_valid_ff;
   logic [15:0]        out_pix_ff;
   smp_row_type        out_row_ff;

   row_type            a, comb, wr_row, res_row;
   logic [LANES-1:0]   act;
   logic signed [ACC_W-1:0] xe [LANES];
   logic               simple, last_lane, out_free, finish_ok, finishing, wr_en, out_load;
   logic signed [ACC_W-1:0] a_cur, x_cur;
   logic [ACC_W-1:0]   ua_cur;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [63:0]        sq_bit, sq_t, sq_rr;
   logic [63:0]        mlo, mm;
   logic [ACC_W-1:0]   mul_res;
   logic [16:0]        div_r2;
   logic               div_ge;
   logic [47:0]        div_q;
   logic               keep;

   // read-during-write returns old data, so the row just written is forwarded
   assign a = fwd_ff ? fwd_row_ff : mem_rd_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         xe[i]  = ACC_W'($signed(ex_ff.x[i]));
         act[i] = (LANE_W'(i) <= ex_ff.lanes_m1);
         comb[i] = a[i];
         if (act[i]) begin
            unique case (ex_ff.op)
               OP_STORE: comb[i] = xe[i];
               OP_ADD:   comb[i] = sat48(49'($signed(a[i])) + 49'(xe[i]));
               OP_MIN:   if (xe[i] < $signed(a[i])) comb[i] = xe[i];
               OP_MAX:   if (xe[i] > $signed(a[i])) comb[i] = xe[i];
               default:  comb[i] = a[i];
            endcase
         end
      end
   end

   assign simple = (ex_ff.op == OP_STORE) || (ex_ff.op == OP_ADD) ||
                   (ex_ff.op == OP_MIN) || (ex_ff.op == OP_MAX);
   assign last_lane = (lane_ff == ex_ff.lanes_m1);
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign finish_ok = !ex_ff.last || out_free;

   assign a_cur  = $signed(a[lane_ff]);
   assign x_cur  = xe[lane_ff];
   assign ua_cur = mag48(a_cur);

   // shared multiplier
   always_comb begin
      unique case (st_ff)
         ST_MUL_LO: begin mul_a = ua_cur[31:0];          mul_b = mag31(x_cur); end
         ST_MUL_HI: begin mul_a = {16'd0, ua_cur[47:32]}; mul_b = mag31(x_cur); end
         ST_SQ_X:   begin mul_a = mag31(x_cur);           mul_b = mag31(x_cur); end
         ST_NSQ: begin
            mul_a = nsel_ff ? mag31(x_cur) : mag31(a_cur);
            mul_b = mul_a;
         end
         default:   begin mul_a = mag31(a_cur);           mul_b = mag31(a_cur); end
      endcase
      mul_p = mul_a * mul_b;
   end

   // product finish: round at bit 15, ties away from zero, saturate
   always_comb begin
      mlo = prod_ff + 64'h8000;
      mm  = {prodh_ff, 16'd0} + {16'd0, mlo[63:16]};
      if ((a_cur[ACC_W-1] ^ x_cur[ACC_W-1]) && (mm != 64'd0))
         mul_res = (mm > 64'h8000_0000_0000) ? NEG48 : ACC_W'(~mm + 64'd1);
      else
         mul_res = (mm > 64'(POS48)) ? POS48 : mm[ACC_W-1:0];
   end

   // sqrt digit step
   always_comb begin
      sq_bit = 64'd1 << {k_ff[4:0], 1'b0};
      sq_t   = sq_r_ff + sq_bit;
      sq_rr  = (sq_n_ff > sq_r_ff) ? sq_r_ff + 64'd1 : sq_r_ff;
   end

   // restoring divide step
   always_comb begin
      div_r2 = {div_rem_ff, div_num_ff[47]};
      div_ge = (div_r2 >= {1'b0, cdiv});
      div_q  = {div_num_ff[46:0], div_ge};
   end

   assign keep = (ex_ff.op == OP_NMIN) ? (nacc_a_ff < nacc_x_ff) : (nacc_a_ff > nacc_x_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (head_valid) st_in = ST_EXEC;
         ST_EXEC: begin
            unique case (ex_ff.op)
               OP_HYPOT:       st_in = ST_SQ_A;
               OP_MUL:         st_in = ST_MUL_LO;
               OP_NMIN, OP_NMAX: st_in = ST_NSQ;
               default: begin
                  if (ex_ff.dvd)      st_in = ST_DIV_LOAD;
                  else if (finish_ok) st_in = head_valid ? ST_EXEC : ST_IDLE;
               end
            endcase
         end
         ST_MUL_LO:  st_in = ST_MUL_HI;
         ST_MUL_HI:  st_in = ST_MUL_FIN;
         ST_MUL_FIN: st_in = !last_lane ? ST_MUL_LO : (ex_ff.dvd ? ST_DIV_LOAD : ST_DONE);
         ST_SQ_A:    st_in = ST_SQ_X;
         ST_SQ_X:    st_in = ST_SQRT;
         ST_SQRT:    if (k_ff == 6'd0) st_in = ST_HYP_FIN;
         ST_HYP_FIN: st_in = !last_lane ? ST_SQ_A : (ex_ff.dvd ? ST_DIV_LOAD : ST_DONE);
         ST_NSQ:     if (nsel_ff && last_lane) st_in = ST_NCMP;
         ST_NCMP:    st_in = ex_ff.dvd ? ST_DIV_LOAD : ST_DONE;
         ST_DIV_LOAD: st_in = ST_DIV;
         ST_DIV:     if (k_ff == 6'd0) st_in = last_lane ? ST_DONE : ST_DIV_LOAD;
         ST_DONE:    if (finish_ok) st_in = head_valid ? ST_EXEC : ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      finishing = ((st_ff == ST_EXEC) && simple && !ex_ff.dvd && finish_ok) ||
                  ((st_ff == ST_DONE) && finish_ok);
      pop      = head_valid && ((st_ff == ST_IDLE) || finishing);
      wr_en    = finishing;
      out_load = finishing && ex_ff.last;
      wr_row   = (st_ff == ST_EXEC) ? comb : new_ff;
      res_row  = (st_ff == ST_EXEC) ? comb : (ex_ff.dvd ? dq_ff : new_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[ex_ff.pixel] <= wr_row;
      if (pop) begin
         mem_rd_ff  <= mem[head.pixel];
         ex_ff      <= head;
         fwd_ff     <= wr_en && (ex_ff.pixel == head.pixel);
         fwd_row_ff <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_EXEC: begin
            new_ff    <= comb;
            lane_ff   <= '0;
            nsel_ff   <= 1'b0;
            nacc_a_ff <= '0;
            nacc_x_ff <= '0;
         end
         ST_MUL_LO: prod_ff  <= mul_p;
         ST_MUL_HI: prodh_ff <= mul_p[47:0];
         ST_MUL_FIN: begin
            new_ff[lane_ff] <= mul_res;
            lane_ff <= last_lane ? '0 : lane_ff + 1'b1;
         end
         ST_SQ_A: sq_n_ff <= mul_p;
         ST_SQ_X: begin
            sq_n_ff <= sq_n_ff + mul_p;
            sq_r_ff <= '0;
            k_ff    <= 6'd31;
         end
         ST_SQRT: begin
            if (sq_n_ff >= sq_t) begin
               sq_n_ff <= sq_n_ff - sq_t;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            k_ff <= k_ff - 6'd1;
         end
         ST_HYP_FIN: begin
            new_ff[lane_ff] <= (sq_rr > 64'h7FFF_FFFF) ? 48'h7FFF_FFFF : sq_rr[ACC_W-1:0];
            lane_ff <= last_lane ? '0 : lane_ff + 1'b1;
         end
         ST_NSQ: begin
            if (nsel_ff) begin
               nacc_x_ff <= nacc_x_ff + 65'(mul_p);
               lane_ff   <= last_lane ? '0 : lane_ff + 1'b1;
            end else begin
               nacc_a_ff <= nacc_a_ff + 65'(mul_p);
            end
            nsel_ff <= ~nsel_ff;
         end
         ST_NCMP: begin
            for (int i = 0; i < LANES; i++)
               if (act[i] && !keep) new_ff[i] <= xe[i];
         end
         ST_DIV_LOAD: begin
            div_num_ff <= mag48($signed(new_ff[lane_ff])) + 48'(cdiv >> 1);
            div_rem_ff <= '0;
            k_ff       <= 6'd47;
         end
         ST_DIV: begin
            div_rem_ff <= div_ge ? 16'(div_r2 - {1'b0, cdiv}) : div_r2[15:0];
            div_num_ff <= div_q;
            k_ff       <= k_ff - 6'd1;
            if (k_ff == 6'd0) begin
               dq_ff[lane_ff] <= new_ff[lane_ff][ACC_W-1] ? (~div_q + 48'd1) : div_q;
               lane_ff <= last_lane ? '0 : lane_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)              out_valid_ff <= 1'b0;
      else if (out_load)      out_valid_ff <= 1'b1;
      else if (rsp_ch.ready)  out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pix_ff <= 16'(ex_ff.pixel);
         for (int i = 0; i < LANES; i++)
            out_row_ff[i] <= act[i] ? clamp32($signed(res_row[i])) : '0;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_pixel = out_pix_ff;
   assign rsp_ch.out_lane0 = out_row_ff[0];
   assign rsp_ch.out_lane1 = out_row_ff[1];
   assign rsp_ch.out_lane2 = out_row_ff[2];
   assign rsp_ch.out_lane3 = out_row_ff[3];

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_ch.ready))
      else $error("result register overwritten");

   a_sqrt_runs: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SQRT && k_ff != 6'd0) |=> (st_ff == ST_SQRT))
      else $error("sqrt sequence cut short");

   a_lanes_wrapped: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DONE) |-> (lane_ff == '0))
      else $error("lane counter not wrapped at finish");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EXEC) |-> $past(pop) || $past(st_ff == ST_EXEC))
      else $error("exec entered without a pop");

endmodule

// ===== tb/sv/psr_scoreboard.sv =====
`timescale 1ns / 100ps
// psr_scoreboard: stack reducer prediction and result checking
// depends on psr_pkg
class psr_scoreboard;
   typedef struct {
      logic [15:0] pixel;
      logic [31:0] lane [4];
   } result_type;

   logic signed [47:0] acc [int];
   logic [2:0]  mode;
   logic [2:0]  channels;
   logic [15:0] images;
   result_type  pending [$];
   int          errors;
   int          checked;

   function new();
      mode = 0;
      channels = 1;
      images = 1;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == psr_pkg::CSR_MODE) mode = data[2:0];
      else if (idx == psr_pkg::CSR_CHANNELS) channels = data[2:0];
      else if (idx == psr_pkg::CSR_IMAGES) images = data;
   endfunction

   function logic [63:0] mag_of(logic signed [47:0] v);
      logic [63:0] m;
      m = v < 0 ? 64'(-$signed(64'(v))) : 64'(v);
      return m;
   endfunction

   function logic [63:0] mag_lim(logic signed [47:0] v);
      logic [63:0] m;
      m = mag_of(v);
      return m > 64'h8000_0000 ? 64'h8000_0000 : m;
   endfunction

   function logic [63:0] root_round(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (n > r) r = r + 1;
      return r;
   endfunction

   function logic signed [47:0] sat(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -128'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   function logic [127:0] sqnorm(logic signed [47:0] v [4], int n);
      logic [127:0] s;
      s = 0;
      for (int i = 0; i < n; i++) s += 128'(mag_lim(v[i])) * 128'(mag_lim(v[i]));
      return s;
   endfunction

   function void note_request(logic [15:0] pix, logic first, logic last,
                              logic signed [31:0] x [4]);
      int n;
      logic signed [47:0] a [4];
      logic [127:0] m, na, nx;
      logic [63:0] c, q;
      logic signed [47:0] v;
      result_type r;
      bit keep;
      n = channels < 1 ? 1 : (channels > 4 ? 4 : channels);
      for (int i = 0; i < 4; i++)
         a[i] = acc.exists(pix * 4 + i) ? acc[pix * 4 + i] : 48'sd0;
      if (first) begin
         for (int i = 0; i < n; i++) a[i] = x[i];
      end else if (mode >= 6) begin
         na = sqnorm(a, n);
         nx = sqnorm('{48'(x[0]), 48'(x[1]), 48'(x[2]), 48'(x[3])}, n);
         keep = mode == psr_pkg::MODE_NMIN ? na < nx : na > nx;
         if (!keep) for (int i = 0; i < n; i++) a[i] = x[i];
      end else begin
         for (int i = 0; i < n; i++) begin
            case (mode)
               psr_pkg::MODE_SUM, psr_pkg::MODE_AVG: a[i] = sat(128'(a[i]) + 128'(x[i]));
               psr_pkg::MODE_HYPOT: begin
                  q = root_round(mag_lim(a[i]) * mag_lim(a[i]) +
                                 mag_lim(48'(x[i])) * mag_lim(48'(x[i])));
                  a[i] = q > 64'h7FFF_FFFF ? 48'sh7FFF_FFFF : 48'(q);
               end
               psr_pkg::MODE_PROD: begin
                  m = (128'(mag_of(a[i])) * 128'(mag_of(48'(x[i]))) + 128'h8000) >> 16;
                  if (((a[i] < 0) != (x[i] < 0)) && m != 0)
                     a[i] = m > (128'd1 << 47) ? 48'sh8000_0000_0000 : 48'(-$signed(m));
                  else
                     a[i] = m > 128'h7FFF_FFFF_FFFF ? 48'sh7FFF_FFFF_FFFF : 48'(m);
               end
               psr_pkg::MODE_MIN: if (x[i] < a[i]) a[i] = x[i];
               default: if (x[i] > a[i]) a[i] = x[i];
            endcase
         end
      end
      for (int i = 0; i < n; i++) acc[pix * 4 + i] = a[i];
      if (!last) return;
      r.pixel = pix;
      for (int i = 0; i < 4; i++) begin
         v = 0;
         if (i < n) begin
            v = a[i];
            if (mode == psr_pkg::MODE_AVG) begin
               c = images == 0 ? 1 : images;
               q = (mag_of(v) + c / 2) / c;
               v = v < 0 ? 48'(-$signed(q)) : 48'(q);
            end
            if (v > 48'sd2147483647) v = 48'sd2147483647;
            if (v < -48'sd2147483648) v = -48'sd2147483648;
         end
         r.lane[i] = v[31:0];
      end
      pending.push_back(r);
   endfunction

   function void check_result(logic [15:0] pix, logic [31:0] y [4]);
      result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result, pixel %0d", $time, pix);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      if (e.pixel !== pix) begin
         $display("%0t: out_pixel expected %0d actual %0d", $time, e.pixel, pix);
         errors++;
      end
      for (int i = 0; i < 4; i++)
         if (e.lane[i] !== y[i]) begin
            $display("%0t: out_lane%0d expected %h actual %h", $time, i, e.lane[i], y[i]);
            errors++;
         end
   endfunction
endclass

// ===== tb/sv/pixelwise_stack_reducer_tb.sv =====
`timescale 1ns / 100ps
// pixelwise_stack_reducer_tb: random and directed stack sequences under all modes
// depends on psr_pkg, psr_ifs, psr_scoreboard and the reducer rtl
module pixelwise_stack_reducer_tb;
   import psr_pkg::*;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [15:0] csr_wr_data;
   bit quiet;
   int sent;

   psr_req_if req_ch ();
   psr_rsp_if rsp_ch ();
   psr_scoreboard board;

   pixelwise_stack_reducer i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("pixelwise_stack_reducer_tb: done, errors");
      $finish;
   end

   // response side: random stall bursts, checks on accept
   initial begin
      int gap;
      rsp_ch.ready = 0;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_result(rsp_ch.out_pixel, '{rsp_ch.out_lane0, rsp_ch.out_lane1,
                                                    rsp_ch.out_lane2, rsp_ch.out_lane3});
         if (gap > 0) gap--;
         else if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
         rsp_ch.ready <= (gap == 0) && !reset;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 0;
      board.write_reg(idx, data);
   endtask

   task automatic send_pixel(logic [15:0] pix, logic first, logic last,
                             logic [31:0] l0, logic [31:0] l1,
                             logic [31:0] l2, logic [31:0] l3);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.pixel_index <= pix;
      req_ch.first_image <= first;
      req_ch.last_image <= last;
      req_ch.lane0 <= l0;
      req_ch.lane1 <= l1;
      req_ch.lane2 <= l2;
      req_ch.lane3 <= l3;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_request(pix, first, last, '{l0, l1, l2, l3});
      sent++;
   endtask

   task automatic drain();
      int waited;
      req_ch.valid <= 0;
      waited = 0;
      while (board.pending.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_lane();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         default: return $urandom;
      endcase
   endfunction

   // one stack of images over a few pixels, image after image
   task automatic run_stack(int pixels, int depth);
      logic [15:0] base;
      base = 16'($urandom);
      if (base > 16'hFFF0) base = 16'hFFF0;
      for (int im = 0; im < depth; im++)
         for (int p = 0; p < pixels; p++)
            send_pixel(16'(base + p), im == 0, im == depth - 1,
                       rand_lane(), rand_lane(), rand_lane(), rand_lane());
   endtask

   initial begin
      int depth;
      board = new();
      quiet = 0;
      sent = 0;
      reset = 1;
      csr_wr_en = 0;
      csr_index = 0;
      csr_wr_data = 0;
      req_ch.valid = 0;
      req_ch.pixel_index = 0;
      req_ch.first_image = 0;
      req_ch.last_image = 0;
      req_ch.lane0 = 0;
      req_ch.lane1 = 0;
      req_ch.lane2 = 0;
      req_ch.lane3 = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, first and last together, each mode
      send_pixel(16'hFFFF, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF);
      drain();
      for (int m = 0; m < 8; m++) begin
         write_reg(CSR_MODE, 16'(m));
         write_reg(CSR_CHANNELS, 16'(m == 0 ? 0 : (m == 7 ? 7 : 4)));
         write_reg(CSR_IMAGES, 16'(m == 1 ? 0 : 3));
         send_pixel(0, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
         send_pixel(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000, 0);
         send_pixel(0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
         drain();
      end

      for (int phase = 0; sent < 1680; phase++) begin
         write_reg(CSR_MODE, 16'($urandom_range(0, 7)));
         write_reg(CSR_CHANNELS,
                   16'(phase % 5 == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4)));
         depth = phase % 9 == 0 ? 1 : $urandom_range(2, 5);
         write_reg(CSR_IMAGES, phase % 7 == 0 ? 16'hFFFF : 16'(depth));
         if (sent > 1400) quiet = 1;
         run_stack($urandom_range(1, 6), depth);
         drain();
      end

      $display("covered %0d requests over all eight modes, %0d results checked",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("pixelwise_stack_reducer_tb: done, clean");
      else
         $display("pixelwise_stack_reducer_tb: done, errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/psr_pkg.sv
rtl/core/psr_ifs.sv
rtl/core/psr_front.sv
rtl/core/psr_queue.sv
rtl/core/psr_back.sv
rtl/core/pixelwise_stack_reducer.sv
tb/sv/psr_scoreboard.sv
tb/sv/pixelwise_stack_reducer_tb.sv
